// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ----- hdl/rtd_pkg.sv -----
`timescale 1ns / 1ps

package rtd_pkg;

  localparam int ColW     = 10;
  localparam int ThrW     = 9;
  localparam int SumW     = 18;
  localparam int ThrKW    = 19;
  localparam int SlotN    = 16;
  localparam int SlotW    = 4;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;

  localparam logic [ColW-1:0] MaxWidth = 10'd512;
  localparam logic [ColW-1:0] WidthRst = 10'd512;
  localparam logic [ThrW-1:0] ThrRst   = 9'd200;
  localparam int              ThrScale = 1000;
  localparam int              RedW     = 299;
  localparam int              GreenW   = 587;
  localparam int              BlueW    = 114;

  localparam logic [CfgIdxW-1:0] CfgLineWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDarkThr   = 1'b1;

  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChReset  = 8'h40;
  localparam logic [7:0] ChUni    = 8'h55;
  localparam logic [7:0] ChOne    = 8'h01;
  localparam logic [7:0] ChSpace  = 8'h30;
  localparam logic [7:0] ChRaster = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h00;
  localparam logic [7:0] ChFeed   = 8'h0C;

  // slot positions inside one pixel's byte run
  localparam int SlotPre  = 0;
  localparam int SlotHdr  = 7;
  localparam int SlotData = 12;
  localparam int SlotTrl  = 13;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       page_end;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } rsp_t;

  typedef struct packed {
    logic [SlotN-1:0] mask;
    logic [7:0]       data;
    logic [ColW-1:0]  width;
  } desc_t;

  function automatic logic [7:0] slot_byte(input logic [SlotW-1:0] idx,
                                           input logic [7:0] data,
                                           input logic [ColW-1:0] width);
    logic [7:0] b;
    case (idx)
      4'd0:    b = ChEsc;
      4'd1:    b = ChReset;
      4'd2:    b = ChEsc;
      4'd3:    b = ChUni;
      4'd4:    b = ChOne;
      4'd5:    b = ChEsc;
      4'd6:    b = ChSpace;
      4'd7:    b = ChEsc;
      4'd8:    b = ChRaster;
      4'd9:    b = ChZero;
      4'd10:   b = width[7:0];
      4'd11:   b = {{(16-ColW){1'b0}}, width[ColW-1:8]};
      4'd12:   b = data;
      4'd13:   b = ChFeed;
      4'd14:   b = ChEsc;
      4'd15:   b = ChReset;
      default: b = ChZero;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/rgb_to_dot_raster_printer_stream.sv -----
// channel | direction | handshake                  | payload
// pixel   | in        | in_valid_i / in_stall_o    | in_req_i  (pix_t)
// bytes   | out       | out_valid_o / out_stall_i  | out_rsp_o (rsp_t)
// config  | in        | cfg_we_i, cfg_idx_i        | cfg_wdata_i
// one pixel per cycle enters while in_stall_o is low
// bytes leave one per cycle unless stalled, 0 to 16 bytes per pixel
// the pixel side stalls only while the request queue is full
// reset: width 512, threshold 200, no page open, column 0
`timescale 1ns / 1ps

module rgb_to_dot_raster_printer_stream import rtd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pix_t                in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsp_t                out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [ColW-1:0]  width_q, width_d;
  logic [ThrKW-1:0] thr_k_q, thr_k_d;
  logic             push, full, pop, empty;
  desc_t            push_desc, head;

  always_comb begin
    width_d = width_q;
    thr_k_d = thr_k_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLineWidth: begin
          if (cfg_wdata_i == '0) begin
            width_d = ColW'(1);
          end else if (cfg_wdata_i > MaxWidth) begin
            width_d = MaxWidth;
          end else begin
            width_d = cfg_wdata_i;
          end
        end
        CfgDarkThr: thr_k_d = ThrKW'(cfg_wdata_i[ThrW-1:0]) * ThrKW'(ThrScale);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthRst;
      thr_k_q <= ThrKW'(ThrRst) * ThrKW'(ThrScale);
    end else begin
      width_q <= width_d;
      thr_k_q <= thr_k_d;
    end
  end

  rtd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .width_i     (width_q),
    .thr_k_i     (thr_k_q),
    .full_i      (full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  rtd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  rtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ----- hdl/rtd_front.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtd_front import rtd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pix_t              in_req_i,
  input  logic [ColW-1:0]   width_i,
  input  logic [ThrKW-1:0]  thr_k_i,
  input  logic              full_i,
  output logic              push_o,
  output desc_t             push_desc_o
);

  logic            a_valid_q, a_valid_d;
  logic [SumW-1:0] a_sum_q, a_sum_d;
  logic            a_last_q, a_last_d;
  logic [ColW-1:0] column_q, column_d;
  logic [7:0]      dot_q, dot_d;
  logic            open_q, open_d;

  logic            accept, consume, dot_bit, hdr, byte_full, dat;
  logic [ColW-1:0] col1;
  logic [7:0]      shift;
  logic [SlotN-1:0] mask;

  assign a_sum_d = SumW'(in_req_i.red) * SumW'(RedW)
                 + SumW'(in_req_i.green) * SumW'(GreenW)
                 + SumW'(in_req_i.blue) * SumW'(BlueW);
  assign a_last_d = in_req_i.page_end;

  always_comb begin
    hdr       = (column_q == '0);
    dot_bit   = ThrKW'(a_sum_q) < thr_k_i;
    shift     = (hdr ? 8'h00 : dot_q) | (dot_bit ? (8'h80 >> column_q[2:0]) : 8'h00);
    col1      = column_q + ColW'(1);
    byte_full = (col1[2:0] == 3'd0) || (col1 >= width_i);
    dat       = byte_full || a_last_q;
    mask      = '0;
    mask[SlotPre +: 7] = {7{!open_q}};
    mask[SlotHdr +: 5] = {5{hdr}};
    mask[SlotData]     = dat;
    mask[SlotTrl +: 3] = {3{a_last_q}};
  end

  assign consume     = a_valid_q && ((mask == '0) || !full_i);
  assign in_stall_o  = a_valid_q && !consume;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = a_valid_q && (mask != '0) && !full_i;
  assign push_desc_o = '{mask: mask, data: shift, width: width_i};

  always_comb begin
    a_valid_d = accept ? 1'b1 : (consume ? 1'b0 : a_valid_q);
    column_d  = column_q;
    dot_d     = dot_q;
    open_d    = open_q;
    if (consume) begin
      column_d = (a_last_q || col1 >= width_i) ? '0 : col1;
      dot_d    = dat ? 8'h00 : shift;
      open_d   = !a_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      column_q  <= '0;
      dot_q     <= '0;
      open_q    <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      column_q  <= column_d;
      dot_q     <= dot_d;
      open_q    <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sum_q  <= a_sum_d;
      a_last_q <= a_last_d;
    end
  end

  `ASSERT_HOLDS(a_column_range, column_q < MaxWidth, "column beyond widest line")
  `ASSERT_NEVER(a_push_full, push_o && full_i, "request pushed into full queue")
  `ASSERT_HOLDS(a_push_nonempty, !push_o || push_desc_o.mask != '0,
    "request with no bytes queued")

endmodule

// ----- hdl/rtd_queue.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtd_queue import rtd_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop ? ((rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  `ASSERT_HOLDS(a_count_range, cnt_q <= CntW'(Depth), "queue count overflow")

endmodule

// ----- hdl/rtd_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtd_back import rtd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  desc_t head_i,
  input  logic  empty_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output rsp_t  out_rsp_o
);

  logic [SlotN-1:0] pend_q, pend_d;
  logic [7:0]       data_q;
  logic [ColW-1:0]  width_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic [SlotN-1:0] low;
  logic [SlotW-1:0] idx;
  logic             single, out_adv;

  always_comb begin
    low = pend_q & (~pend_q + SlotN'(1));
    idx = '0;
    for (int i = SlotN - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = SlotW'(i);
      end
    end
  end

  assign single  = (pend_q != '0) && ((pend_q & ~low) == '0);
  assign out_adv = !out_valid_q || !out_stall_i;
  assign pop_o   = !empty_i && ((pend_q == '0) || (out_adv && single));

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    if (out_adv) begin
      out_valid_d = (pend_q != '0);
      out_d       = '{out_byte: slot_byte(idx, data_q, width_q), run_last: single};
      pend_d      = pend_q & ~low;
    end
    if (pop_o) begin
      pend_d = head_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o) begin
      data_q  <= head_i.data;
      width_q <= head_i.width;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `ASSERT_HOLDS(a_run_contiguous,
    out_valid_q && !out_stall_i && !out_q.run_last |=> out_valid_q,
    "byte run of one pixel broken")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rtd_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pix_t                in_req_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rsp_t                out_rsp_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  rgb_to_dot_raster_printer_stream dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pix_t pixel_q[$];
  rsp_t cmd_byte_q[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  // printer state mirror
  logic [ColW-1:0] width_reg = WidthRst;
  logic [ThrW-1:0] thr_reg = ThrRst;
  logic [ColW-1:0] col_pos = '0;
  logic [7:0]      dot_acc = '0;
  logic            page_started = 1'b0;

  task automatic predict_pixel(input pix_t px);
    logic [ColW-1:0] eff_w;
    logic [7:0]      run_q[$];
    int unsigned     luma_sum;
    bit              byte_sent;
    rsp_t            rsp;
    eff_w = width_reg;
    byte_sent = 1'b0;
    if (eff_w == '0) eff_w = ColW'(1);
    if (eff_w > MaxWidth) eff_w = MaxWidth;
    if (!page_started) begin
      run_q = '{ChEsc, ChReset, ChEsc, ChUni, ChOne, ChEsc, ChSpace};
      page_started = 1'b1;
    end
    if (col_pos == '0) begin
      run_q.push_back(ChEsc);
      run_q.push_back(ChRaster);
      run_q.push_back(ChZero);
      run_q.push_back(eff_w[7:0]);
      run_q.push_back({6'd0, eff_w[9:8]});
      dot_acc = '0;
    end
    luma_sum = px.red * RedW + px.green * GreenW + px.blue * BlueW;
    if (luma_sum < thr_reg * ThrScale) dot_acc[3'd7 - col_pos[2:0]] = 1'b1;
    col_pos = col_pos + 1'b1;
    if (col_pos[2:0] == 3'd0 || col_pos >= eff_w) begin
      run_q.push_back(dot_acc);
      dot_acc = '0;
      byte_sent = 1'b1;
    end
    if (col_pos >= eff_w) col_pos = '0;
    if (px.page_end) begin
      // partial byte flushed when the page stops mid-line
      if (col_pos != '0 && !byte_sent && col_pos[2:0] != 3'd0) run_q.push_back(dot_acc);
      col_pos = '0;
      dot_acc = '0;
      run_q.push_back(ChFeed);
      run_q.push_back(ChEsc);
      run_q.push_back(ChReset);
      page_started = 1'b0;
    end
    foreach (run_q[i]) begin
      rsp.out_byte = run_q[i];
      rsp.run_last = (i == run_q.size() - 1);
      cmd_byte_q.push_back(rsp);
    end
  endtask

  // pixel request driver
  always @(posedge clk_i) begin
    logic fire;
    fire = in_valid_i && !in_stall_o;
    if (fire) begin
      predict_pixel(pixel_q[0]);
      void'(pixel_q.pop_front());
    end
    if (in_valid_i && !fire) begin
      in_valid_i <= 1'b1;
    end else if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid_i <= 1'b1;
      in_req_i <= pixel_q[0];
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // command byte monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (out_valid_o && !out_stall_i) begin
      if (cmd_byte_q.size() == 0) begin
        $error("unexpected byte %h", out_rsp_o.out_byte);
        errors++;
      end else begin
        want = cmd_byte_q.pop_front();
        if (out_rsp_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_rsp_o.out_byte);
          errors++;
        end
        if (out_rsp_o.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_rsp_o.run_last);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic push_pixel(input int r, input int g, input int b, input bit pe);
    pix_t px;
    px.red = 8'(r);
    px.green = 8'(g);
    px.blue = 8'(b);
    px.page_end = pe;
    pixel_q.push_back(px);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || cmd_byte_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CfgDataW'(value);
    if (idx == CfgLineWidth) width_reg = ColW'(value);
    else thr_reg = ThrW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_level();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int page_left;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings, page ends mid-line, silent pixel
    push_pixel(0, 0, 0, 0);
    push_pixel(255, 255, 255, 0);
    push_pixel(255, 0, 0, 0);
    push_pixel(0, 0, 255, 1);
    drain();

    // zero width acts as one, zero threshold prints nothing
    write_reg(CfgLineWidth, 0);
    write_reg(CfgDarkThr, 0);
    push_pixel(0, 0, 0, 0);
    push_pixel(0, 0, 0, 1);
    drain();

    // oversize width saturates, top threshold
    write_reg(CfgLineWidth, 1023);
    write_reg(CfgDarkThr, 256);
    push_pixel(255, 255, 255, 0);
    push_pixel(128, 128, 128, 0);
    drain();

    // width shrinks mid-line
    write_reg(CfgLineWidth, 16);
    write_reg(CfgDarkThr, 128);
    push_pixel(0, 255, 0, 0);
    push_pixel(10, 200, 30, 0);
    push_pixel(255, 255, 0, 0);
    drain();
    write_reg(CfgLineWidth, 3);
    push_pixel(0, 0, 0, 0);
    push_pixel(90, 90, 90, 0);
    push_pixel(255, 0, 255, 1);
    drain();

    // full byte closes the line right at page end, then a one-pixel page
    write_reg(CfgLineWidth, 8);
    write_reg(CfgDarkThr, 200);
    for (int i = 0; i < 8; i++) push_pixel(i[0] ? 255 : 0, i[1] ? 255 : 0, 120, i == 7);
    push_pixel(0, 255, 0, 1);
    drain();

    // random pages under each pacing mode
    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct = (mode == 1) ? 46 : (mode == 3) ? 8 : 0;
      stall_pct = (mode == 2) ? 46 : (mode == 3) ? 8 : 0;
      if (mode == 1) write_reg(CfgLineWidth, 512);
      else if (mode == 3) write_reg(CfgLineWidth, $urandom_range(513, 1023));
      else write_reg(CfgLineWidth, $urandom_range(1, 40));
      write_reg(CfgDarkThr, $urandom_range(256));
      page_left = $urandom_range(1, 30);
      for (int i = 0; i < 40; i++) begin
        if (mode == 2 && i == 20) drain();
        page_left--;
        push_pixel(pick_level(), pick_level(), pick_level(), page_left == 0);
        if (page_left == 0) page_left = $urandom_range(1, 30);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
